[hdl/slr_pkg.sv]
`default_nettype none

package slr_pkg;

    localparam int unsigned VAL_W  = 31;
    localparam int unsigned MULT_W = 15;
    localparam int unsigned PROD_W = VAL_W + MULT_W;

    localparam logic [MULT_W-1:0] LCG_MULT    = 15'd16807;
    localparam logic [VAL_W-1:0]  LCG_MOD     = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  CLAMP_LIMIT = 31'd2147483390;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_FOLD,
        ST_GEN_MUL,
        ST_GEN_FOLD,
        ST_READ,
        ST_DONE
    } t_state;

    // product of the multiplier folded back mod 2^31-1
    function automatic logic [VAL_W-1:0] lcg_fold(input logic [PROD_W-1:0] p);
        logic [VAL_W:0] s;
        s = {1'b0, p[VAL_W-1:0]} + {{(VAL_W+1-MULT_W){1'b0}}, p[PROD_W-1:VAL_W]};
        if (s >= {1'b0, LCG_MOD}) begin
            s = s - {1'b0, LCG_MOD};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/slr_ram.sv]
`default_nettype none

module slr_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/shuffled_lcg_random_unit.sv]
// a request steps through GEN_MUL, GEN_FOLD, READ and DONE; result stalls hold it in DONE
// reseed (restart set, or first request after reset) adds TABLE_SIZE+WARMUP_STEPS seed steps
// requests are taken only in ST_IDLE; one shared multiply/fold unit does each step as MUL
// then FOLD, and the slot index comes from parallel compares against the slot boundaries
// reset: synchronous active low; seed returns to 1 and the generator counts as unseeded
// the shuffle table is not cleared, the first request after reset reseeds before reading it
`default_nettype none

module shuffled_lcg_random_unit
    import slr_pkg::*;
#(
    parameter int unsigned TABLE_SIZE   = 32,
    parameter int unsigned WARMUP_STEPS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // request channel
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_restart,
    // result channel
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [VAL_W-1:0]    o_value,
    output logic                o_clamped,
    // seed register write channel
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [VAL_W-1:0]    i_cfg_data
);

    // slot index width
    localparam int unsigned AW = $clog2(TABLE_SIZE);
    // step counter covers the whole reseed sweep
    localparam int unsigned CW = $clog2(TABLE_SIZE + WARMUP_STEPS);
    localparam longint unsigned SLOT_DIV = 1 + 64'd2147483646 / TABLE_SIZE;
    localparam logic [CW-1:0]  SEED_STEPS = CW'(TABLE_SIZE + WARMUP_STEPS - 1);
    localparam logic [CW:0]    TBL_LIMIT  = (CW+1)'(TABLE_SIZE);

    t_state              r_state, n_state;
    logic [VAL_W-1:0]    r_seed;
    logic [VAL_W-1:0]    r_gen;
    logic [VAL_W-1:0]    r_last;
    logic [PROD_W-1:0]   r_prod;
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;

    logic                in_acc;
    logic                need_seed;
    logic                out_free;
    logic [VAL_W-1:0]    fold_val;
    logic [VAL_W-1:0]    seed_fix;
    logic [AW-1:0]       slot;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [VAL_W-1:0]    ram_rdata;

    assign in_acc    = i_valid && o_ready;
    // an unseeded generator always reseeds, whatever restart says
    assign need_seed = i_restart || (r_last == '0);
    // result register can take a new word
    assign out_free  = !r_out_valid || i_ready;
    assign fold_val  = lcg_fold(r_prod);
    // zero is a fixed point of the map and the modulus itself maps to zero
    assign seed_fix  = ((r_seed == '0) || (r_seed == LCG_MOD)) ? VAL_W'(1) : r_seed;

    // slot = previous output / SLOT_DIV, one compare per slot boundary
    always_comb begin
        slot = '0;
        for (int k = 1; k < TABLE_SIZE; k++) begin
            if (r_last >= VAL_W'(SLOT_DIV * 64'(k))) begin
                slot = AW'(k);
            end
        end
    end

    // seed register, writes land only while idle
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= VAL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = need_seed ? ST_SEED_MUL : ST_GEN_MUL;
                end
            end
            ST_SEED_MUL:  n_state = ST_SEED_FOLD;
            ST_SEED_FOLD: n_state = (r_cnt == '0) ? ST_GEN_MUL : ST_SEED_MUL;
            ST_GEN_MUL:   n_state = ST_GEN_FOLD;
            ST_GEN_FOLD:  n_state = ST_READ;
            ST_READ:      n_state = ST_DONE;
            ST_DONE:      n_state = out_free ? ST_IDLE : ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and table write port
    always_comb begin
        o_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = r_gen;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_SEED_FOLD: begin
                // the last TABLE_SIZE steps fill the table from the top slot down
                ram_we    = ({1'b0, r_cnt} < TBL_LIMIT);
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = fold_val;
            end
            ST_DONE: ram_we = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // generator and step counter datapath
    always_ff @(posedge i_clk) begin
        case (r_state) inside
            ST_IDLE: begin
                if (in_acc && need_seed) begin
                    r_gen <= seed_fix;
                    r_cnt <= SEED_STEPS;
                end
            end
            ST_SEED_MUL, ST_GEN_MUL: begin
                r_prod <= PROD_W'(r_gen) * PROD_W'(LCG_MULT);
            end
            ST_SEED_FOLD: begin
                r_gen <= fold_val;
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            ST_GEN_FOLD: begin
                r_gen <= fold_val;
            end
            default: ;
        endcase
    end

    // last output: slot 0 after a reseed, the table word after a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if ((r_state == ST_SEED_FOLD) && (r_cnt == '0)) begin
            r_last <= fold_val;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_last <= ram_rdata;
        end
    end

    // result register parts the sequencer from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_value <= ram_rdata;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_value   = r_out_value;
    assign o_clamped = (r_out_value >= CLAMP_LIMIT);

    // shuffle table, read port follows the slot index
    slr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    a_restart_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_restart) |=> (r_state == ST_SEED_MUL))
        else $error("restart transaction did not start a reseed");

    a_seeded_before_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN_FOLD) |-> (r_last != '0))
        else $error("generator stepped while unseeded");

    a_cfg_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> ((r_state == ST_IDLE) && !i_valid))
        else $error("seed written while a transaction was in flight");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_value != '0) && (o_value != LCG_MOD)))
        else $error("result outside generator range");

    a_done_updates_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && out_free) |=> (o_valid && (r_last == o_value)))
        else $error("result and last output disagree");

endmodule

`default_nettype wire

[dv/shuffled_lcg_random_unit_tb.sv]
`timescale 1ns / 1ps
`default_nettype none

module shuffled_lcg_random_unit_tb
    import slr_pkg::*;
();

    // block geometry, kept at the defaults of the unit
    localparam int unsigned TBL_SIZE     = 32;
    localparam int unsigned WARMUP       = 8;
    localparam int unsigned SLOT_DIV     = 1 + (32'h7FFF_FFFE / TBL_SIZE);
    localparam realtime     HALF_PERIOD  = 6.0;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_DRAWS  = 200;
    localparam logic [VAL_W-1:0] SEED_ALL_ONES = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             clamped;
    } t_draw;

    // dut inputs, all driven to known values from time zero
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_ready;
    logic             i_restart   = 1'b0;
    logic             o_valid;
    logic             i_ready     = 1'b0;
    logic [VAL_W-1:0] o_value;
    logic             o_clamped;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [VAL_W-1:0] i_cfg_data  = '0;

    // predictor state: seed register, generator, shuffle slots, last word out
    logic [VAL_W-1:0] mdl_seed;
    logic [VAL_W-1:0] mdl_gen;
    logic [VAL_W-1:0] mdl_slots [TBL_SIZE];
    logic [VAL_W-1:0] mdl_last;

    // draws predicted but not yet seen on the result channel
    t_draw pending_draws [$];

    // run bookkeeping
    int unsigned fail_count    = 0;
    int unsigned n_requests    = 0;
    int unsigned n_restarts    = 0;
    int unsigned n_reseeds     = 0;
    int unsigned n_draws_seen  = 0;
    int unsigned n_clamped     = 0;
    int unsigned n_seed_writes = 0;

    // idling controls shared with the result side
    bit          no_idle   = 1'b0;
    int unsigned hold_req  = 0;

    shuffled_lcg_random_unit #(
        .TABLE_SIZE   (TBL_SIZE),
        .WARMUP_STEPS (WARMUP)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_clamped   (o_clamped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one minimal-standard step, x * 16807 mod 2^31-1 in plain 64-bit math
    function automatic logic [VAL_W-1:0] minstd_next(input logic [VAL_W-1:0] x);
        logic [63:0] prod;
        prod = {33'd0, x} * 64'(LCG_MULT);
        return VAL_W'(prod % 64'(LCG_MOD));
    endfunction

    // reseed: zero and 2^31-1 both collapse to one, warm up, then fill slots top down
    function automatic void refill_slots();
        logic [VAL_W-1:0] x;
        x = mdl_seed;
        if (x == '0 || x == LCG_MOD) begin
            x = VAL_W'(1);
        end
        for (int n = TBL_SIZE + WARMUP - 1; n >= 0; n--) begin
            x = minstd_next(x);
            if (n < TBL_SIZE) begin
                mdl_slots[n] = x;
            end
        end
        mdl_gen  = x;
        mdl_last = mdl_slots[0];
        n_reseeds++;
    endfunction

    // work out the draw caused by one accepted request and queue it
    function automatic void predict_draw(input logic restart);
        int unsigned slot;
        logic [VAL_W-1:0] word;
        t_draw d;
        // unseeded generator forces a reseed whatever restart says
        if (restart || mdl_last == '0) begin
            refill_slots();
        end
        mdl_gen = minstd_next(mdl_gen);
        slot    = mdl_last / SLOT_DIV;
        if (slot >= TBL_SIZE) begin
            slot = TBL_SIZE - 1;
        end
        word            = mdl_slots[slot];
        mdl_slots[slot] = mdl_gen;
        mdl_last        = word;
        d.value   = word;
        d.clamped = (word >= CLAMP_LIMIT);
        pending_draws.push_back(d);
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request; valid is only lowered when an idle gap is drawn
    task automatic send_request(input logic restart);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // transaction taken at this edge
        predict_draw(restart);
        n_requests++;
        if (restart) begin
            n_restarts++;
        end
    endtask

    // stop offering and wait until every predicted draw has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid   <= 1'b0;
        i_restart <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    // seed register write, only issued while the unit is idle
    task automatic write_seed(input logic [VAL_W-1:0] seed);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mdl_seed = seed;
        n_seed_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request, field checks
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        t_draw exp_d;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                // long stall counted here so the request side backs up
                i_ready <= 1'b0;
                repeat (hold_req) @(negedge i_clk);
                hold_req = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 4);
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            // result transaction at this edge
            n_draws_seen++;
            if (pending_draws.size() == 0) begin
                $error("unexpected result: value %0d clamped %0b", o_value, o_clamped);
                fail_count++;
            end else begin
                exp_d = pending_draws.pop_front();
                if (o_value !== exp_d.value) begin
                    $error("value mismatch: expected %0d, got %0d", exp_d.value, o_value);
                    fail_count++;
                end
                if (o_clamped !== exp_d.clamped) begin
                    $error("clamped mismatch: expected %0b, got %0b",
                           exp_d.clamped, o_clamped);
                    fail_count++;
                end
                if (exp_d.clamped) begin
                    n_clamped++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // default seed of one, first request must reseed even without restart
    task automatic test_first_after_reset();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();
    endtask

    // extreme seeds: zero, one, largest legal, all ones (same as zero mod m), bit patterns
    task automatic test_seed_extremes();
        logic [VAL_W-1:0] seeds [6];
        seeds = '{31'd0, 31'd1, 31'h7FFF_FFFE, SEED_ALL_ONES, 31'h5555_5555, 31'h2AAA_AAAA};
        foreach (seeds[k]) begin
            write_seed(seeds[k]);
            // new seed must not touch the running sequence until a restart
            send_request(1'b0);
            send_request(1'b1);
            send_request(1'b0);
            drain();
        end
    endtask

    // random streams under fresh seeds, sparse restarts, some phases without idling
    task automatic test_random_streams();
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            no_idle = (ph % 3 == 2);
            if (ph % 4 == 3) begin
                write_seed(VAL_W'($urandom_range(0, 3)));
            end else begin
                write_seed(VAL_W'($urandom()));
            end
            send_request(1'b1);
            for (int unsigned k = 1; k < PHASE_DRAWS; k++) begin
                send_request($urandom_range(0, 19) == 0);
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        write_seed(VAL_W'($urandom()));
        hold_req = HOLD_CYCLES;
        for (int unsigned k = 0; k < 40; k++) begin
            send_request(k == 0 || $urandom_range(0, 9) == 0);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        // predictor starts from the unit's reset state
        mdl_seed = VAL_W'(1);
        mdl_gen  = '0;
        mdl_last = '0;
        foreach (mdl_slots[k]) begin
            mdl_slots[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_after_reset();
        test_seed_extremes();
        test_random_streams();
        test_backpressure();

        // any late result in this window is flagged by the checker
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d with restart, %0d reseeds), %0d results, %0d clamped",
                 n_requests, n_restarts, n_reseeds, n_draws_seen, n_clamped);
        $display("seed register written %0d times, including zero, one and all-ones seeds",
                 n_seed_writes);
        if (fail_count == 0) begin
            $display("PASS shuffled_lcg_random_unit");
        end else begin
            $display("FAIL shuffled_lcg_random_unit");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", pending_draws.size());
        $display("FAIL shuffled_lcg_random_unit");
        $finish;
    end

endmodule

`default_nettype wire
